>>> hw/rtl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and the control store for the character LCD write
// sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

   // Request kinds as they arrive on the input channel.
   localparam logic [2:0] KIND_CMD    = 3'd0;
   localparam logic [2:0] KIND_CHAR   = 3'd1;
   localparam logic [2:0] KIND_CURSOR = 3'd2;
   localparam logic [2:0] KIND_INT    = 3'd3;
   localparam logic [2:0] KIND_INIT   = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PULSE      = 2'd0;
   localparam logic [1:0] CSR_SETTLE     = 2'd1;
   localparam logic [1:0] CSR_POWER_WAIT = 2'd2;

   localparam int unsigned TIME_W = 10;
   localparam int unsigned PC_W   = 4;

   localparam logic [TIME_W-1:0] PULSE_RESET      = 10'd100;
   localparam logic [TIME_W-1:0] SETTLE_RESET     = 10'd500;
   localparam logic [TIME_W-1:0] POWER_WAIT_RESET = 10'd100;

   // Byte constants of the display protocol.
   localparam logic [7:0] LINE0_BASE = 8'h80;
   localparam logic [7:0] LINE1_BASE = 8'hC0;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] INIT_CMD0  = 8'h33;
   localparam logic [7:0] INIT_CMD1  = 8'h32;
   localparam logic [7:0] INIT_CMD2  = 8'h28;
   localparam logic [7:0] INIT_CMD3  = 8'h0C;
   localparam logic [7:0] INIT_CMD4  = 8'h01;
   localparam logic [7:0] INIT_CMD5  = 8'h06;
   localparam logic [7:0] INIT_CMD6  = 8'h02;

   // Decimal conversion.
   localparam int unsigned MAX_DIGITS = 10;
   localparam int unsigned DIG_CNT_W  = 4;
   localparam logic [63:0] RECIP_TEN  = 64'h0000_0000_CCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;

   // Byte phase counter: five phases per byte.
   localparam logic [2:0] PH_HI_SETUP = 3'd0;
   localparam logic [2:0] PH_HI_PULSE = 3'd1;
   localparam logic [2:0] PH_LO_SETUP = 3'd2;
   localparam logic [2:0] PH_LO_PULSE = 3'd3;
   localparam logic [2:0] PH_SETTLE   = 3'd4;

   // Micro-operation of a control word.
   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_WAIT = 2'd1,
      OP_CONV = 2'd2
   } op_type;

   // Where the byte of a byte step comes from.
   typedef enum logic [1:0] {
      SRC_IN     = 2'd0,
      SRC_CURSOR = 2'd1,
      SRC_DIGIT  = 2'd2,
      SRC_CONST  = 2'd3
   } src_type;

   // Sequencing after a step completes.
   typedef enum logic [1:0] {
      JMP_NEXT  = 2'd0,
      JMP_END   = 2'd1,
      JMP_DIGIT = 2'd2
   } jmp_type;

   typedef struct packed {
      op_type          op;
      src_type         src;
      logic            rs;
      logic [7:0]      const_byte;
      jmp_type         jmp;
      logic [PC_W-1:0] target;
   } ucode_word_type;

   // Program entry points.
   localparam logic [PC_W-1:0] PC_CMD      = 4'd0;
   localparam logic [PC_W-1:0] PC_CHAR     = 4'd1;
   localparam logic [PC_W-1:0] PC_CURSOR   = 4'd2;
   localparam logic [PC_W-1:0] PC_INT      = 4'd3;
   localparam logic [PC_W-1:0] PC_INT_LOOP = 4'd4;
   localparam logic [PC_W-1:0] PC_INIT     = 4'd5;

   // One pin phase as it leaves the block.
   typedef struct packed {
      logic              reg_select;
      logic              enable;
      logic [3:0]        nibble;
      logic [TIME_W-1:0] hold_us;
      logic              last;
   } phase_type;

   // Sequencer to digit unit.
   typedef struct packed {
      logic load;
      logic pop;
   } dig_ctl_type;

   // Digit unit to sequencer.
   typedef struct packed {
      logic       busy;
      logic       more;
      logic [3:0] digit;
   } dig_stat_type;

   function automatic ucode_word_type make_word(input op_type op, input src_type src,
                                                input logic rs, input logic [7:0] cb,
                                                input jmp_type jmp,
                                                input logic [PC_W-1:0] target);
      ucode_word_type w;
      w.op         = op;
      w.src        = src;
      w.rs         = rs;
      w.const_byte = cb;
      w.jmp        = jmp;
      w.target     = target;
      return w;
   endfunction

   // The control store.
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_word_type w;
      unique case (addr)
         4'd0:    w = make_word(OP_BYTE, SRC_IN, 1'b0, 8'h00, JMP_END, PC_CMD);
         4'd1:    w = make_word(OP_BYTE, SRC_IN, 1'b1, 8'h00, JMP_END, PC_CMD);
         4'd2:    w = make_word(OP_BYTE, SRC_CURSOR, 1'b0, 8'h00, JMP_END, PC_CMD);
         4'd3:    w = make_word(OP_CONV, SRC_DIGIT, 1'b1, 8'h00, JMP_NEXT, PC_CMD);
         4'd4:    w = make_word(OP_BYTE, SRC_DIGIT, 1'b1, 8'h00, JMP_DIGIT, PC_INT_LOOP);
         4'd5:    w = make_word(OP_WAIT, SRC_CONST, 1'b0, 8'h00, JMP_NEXT, PC_CMD);
         4'd6:    w = make_word(OP_BYTE, SRC_CONST, 1'b0, INIT_CMD0, JMP_NEXT, PC_CMD);
         4'd7:    w = make_word(OP_BYTE, SRC_CONST, 1'b0, INIT_CMD1, JMP_NEXT, PC_CMD);
         4'd8:    w = make_word(OP_BYTE, SRC_CONST, 1'b0, INIT_CMD2, JMP_NEXT, PC_CMD);
         4'd9:    w = make_word(OP_BYTE, SRC_CONST, 1'b0, INIT_CMD3, JMP_NEXT, PC_CMD);
         4'd10:   w = make_word(OP_BYTE, SRC_CONST, 1'b0, INIT_CMD4, JMP_NEXT, PC_CMD);
         4'd11:   w = make_word(OP_BYTE, SRC_CONST, 1'b0, INIT_CMD5, JMP_NEXT, PC_CMD);
         4'd12:   w = make_word(OP_BYTE, SRC_CONST, 1'b0, INIT_CMD6, JMP_END, PC_CMD);
         default: w = make_word(OP_WAIT, SRC_CONST, 1'b0, 8'h00, JMP_END, PC_CMD);
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/clcd_if.sv
// ----------------------------------------------------------------------------
// clcd_req_if / clcd_rsp_if
// Valid/ready channels for requests and pin phases.
// ----------------------------------------------------------------------------
interface clcd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  byte_value;
   logic        row;
   logic [5:0]  column;
   logic [31:0] number;

   modport source (output valid, kind, byte_value, row, column, number, input ready);
   modport sink   (input valid, kind, byte_value, row, column, number, output ready);
endinterface

interface clcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic       enable;
   logic [3:0] nibble;
   logic [9:0] hold_us;
   logic       last;

   modport source (output valid, reg_select, enable, nibble, hold_us, last, input ready);
   modport sink   (input valid, reg_select, enable, nibble, hold_us, last, output ready);
endinterface

>>> hw/rtl/clcd_digits.sv
// ----------------------------------------------------------------------------
// clcd_digits
// Decimal digit unit: splits a 32-bit value into digits, one per cycle,
// and hands them back most significant first.
// ----------------------------------------------------------------------------
module clcd_digits (
   input  logic                  clock,
   input  logic                  reset,
   input  clcd_pkg::dig_ctl_type ctl,
   input  logic [31:0]           number,
   output clcd_pkg::dig_stat_type stat
);

   logic [31:0]                    num_ff, num_in;
   logic [clcd_pkg::DIG_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic [3:0]                     dig_ff [clcd_pkg::MAX_DIGITS];
   logic [63:0]                    prod;
   logic [31:0]                    quot;
   logic [31:0]                    rem_full;
   logic [clcd_pkg::DIG_CNT_W-1:0] rd_idx;

   // Divide by ten through the reciprocal, then the remainder by shift-add.
   always_comb begin
      prod     = 64'(num_ff) * clcd_pkg::RECIP_TEN;
      quot     = 32'(prod >> clcd_pkg::RECIP_SHIFT);
      rem_full = num_ff - (quot << 3) - (quot << 1);
   end

   // Conversion and pop bookkeeping.
   always_comb begin
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctl.load) begin
         num_in  = number;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = quot;
         cnt_in = cnt_ff + 4'd1;
         if (quot == 32'd0) begin
            busy_in = 1'b0;
         end
      end else if (ctl.pop) begin
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      num_ff <= num_in;
   end

   // Digit store, written in conversion order.
   always_ff @(posedge clock) begin
      if (busy_ff && !ctl.load) begin
         dig_ff[cnt_ff] <= rem_full[3:0];
      end
   end

   // The most significant digit still held sits at the top.
   always_comb begin
      rd_idx     = cnt_ff - 4'd1;
      stat.busy  = busy_ff;
      stat.more  = (cnt_ff > 4'd1);
      stat.digit = dig_ff[rd_idx];
   end

endmodule

>>> hw/rtl/clcd_seq.sv
// ----------------------------------------------------------------------------
// clcd_seq
// Microcoded sequencer: a program counter steps through the control store
// and a phase counter walks each byte through its five pin phases.
// ----------------------------------------------------------------------------
module clcd_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2:0]                    kind,
   input  logic [7:0]                    byte_value,
   input  logic                          row,
   input  logic [5:0]                    column,
   input  logic [clcd_pkg::TIME_W-1:0]   pulse_us,
   input  logic [clcd_pkg::TIME_W-1:0]   settle_us,
   input  logic [clcd_pkg::TIME_W-1:0]   power_wait_us,
   input  logic                          out_free,
   input  clcd_pkg::dig_stat_type        dig_stat,
   output logic                          idle,
   output logic                          emit,
   output clcd_pkg::phase_type           phase,
   output clcd_pkg::dig_ctl_type         dig_ctl
);

   logic                        running_ff, running_in;
   logic [clcd_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic [2:0]                  ph_ff, ph_in;
   logic [7:0]                  byte_ff;
   logic                        row_ff;
   logic [5:0]                  col_ff;
   clcd_pkg::ucode_word_type    word;
   logic [7:0]                  cur_byte;
   logic [7:0]                  line_base;
   logic                        final_phase;
   logic                        step_done;
   logic                        end_here;
   logic                        entry_ok;
   logic [clcd_pkg::PC_W-1:0]   entry_pc;

   // Entry point for each request kind; unknown kinds start nothing.
   always_comb begin
      entry_ok = 1'b1;
      entry_pc = clcd_pkg::PC_CMD;
      unique case (kind)
         clcd_pkg::KIND_CMD:    entry_pc = clcd_pkg::PC_CMD;
         clcd_pkg::KIND_CHAR:   entry_pc = clcd_pkg::PC_CHAR;
         clcd_pkg::KIND_CURSOR: entry_pc = clcd_pkg::PC_CURSOR;
         clcd_pkg::KIND_INT:    entry_pc = clcd_pkg::PC_INT;
         clcd_pkg::KIND_INIT:   entry_pc = clcd_pkg::PC_INIT;
         default:               entry_ok = 1'b0;
      endcase
   end

   // Byte selection for the current step.
   always_comb begin
      word      = clcd_pkg::ucode_rom(pc_ff);
      line_base = row_ff ? clcd_pkg::LINE1_BASE : clcd_pkg::LINE0_BASE;
      unique case (word.src)
         clcd_pkg::SRC_IN:     cur_byte = byte_ff;
         clcd_pkg::SRC_CURSOR: cur_byte = line_base + {2'b00, col_ff};
         clcd_pkg::SRC_DIGIT:  cur_byte = clcd_pkg::ASCII_ZERO + {4'h0, dig_stat.digit};
         clcd_pkg::SRC_CONST:  cur_byte = word.const_byte;
         default:              cur_byte = word.const_byte;
      endcase
   end

   // Step completion and program flow.
   always_comb begin
      emit        = running_ff && (word.op != clcd_pkg::OP_CONV) && out_free;
      final_phase = (word.op == clcd_pkg::OP_WAIT) || (ph_ff == clcd_pkg::PH_SETTLE);
      end_here    = (word.jmp == clcd_pkg::JMP_END) ||
                    ((word.jmp == clcd_pkg::JMP_DIGIT) && !dig_stat.more);
      unique case (word.op)
         clcd_pkg::OP_CONV: step_done = running_ff && !dig_stat.busy;
         clcd_pkg::OP_WAIT: step_done = emit;
         clcd_pkg::OP_BYTE: step_done = emit && (ph_ff == clcd_pkg::PH_SETTLE);
         default:           step_done = emit;
      endcase

      dig_ctl.load = start && (kind == clcd_pkg::KIND_INT);
      dig_ctl.pop  = step_done && (word.jmp == clcd_pkg::JMP_DIGIT);

      running_in = running_ff;
      pc_in      = pc_ff;
      ph_in      = ph_ff;
      if (start) begin
         running_in = entry_ok;
         pc_in      = entry_pc;
         ph_in      = clcd_pkg::PH_HI_SETUP;
      end else if (step_done) begin
         ph_in = clcd_pkg::PH_HI_SETUP;
         if (end_here) begin
            running_in = 1'b0;
         end else if (word.jmp == clcd_pkg::JMP_NEXT) begin
            pc_in = pc_ff + 4'd1;
         end else begin
            pc_in = word.target;
         end
      end else if (emit) begin
         ph_in = ph_ff + 3'd1;
      end
   end

   // Pin levels and hold time of the current phase.
   always_comb begin
      phase.reg_select = word.rs;
      phase.enable     = 1'b0;
      phase.nibble     = cur_byte[3:0];
      phase.hold_us    = '0;
      phase.last       = end_here && final_phase;
      if (word.op == clcd_pkg::OP_WAIT) begin
         phase.reg_select = 1'b0;
         phase.nibble     = 4'h0;
         phase.hold_us    = power_wait_us;
      end else begin
         unique case (ph_ff)
            clcd_pkg::PH_HI_SETUP: phase.nibble = cur_byte[7:4];
            clcd_pkg::PH_HI_PULSE: begin
               phase.nibble  = cur_byte[7:4];
               phase.enable  = 1'b1;
               phase.hold_us = pulse_us;
            end
            clcd_pkg::PH_LO_SETUP: phase.nibble = cur_byte[3:0];
            clcd_pkg::PH_LO_PULSE: begin
               phase.enable  = 1'b1;
               phase.hold_us = pulse_us;
            end
            default: phase.hold_us = settle_us;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         pc_ff      <= '0;
         ph_ff      <= '0;
      end else begin
         running_ff <= running_in;
         pc_ff      <= pc_in;
         ph_ff      <= ph_in;
      end
   end

   // Request fields held for the duration of the program.
   always_ff @(posedge clock) begin
      if (start) begin
         byte_ff <= byte_value;
         row_ff  <= row;
         col_ff  <= column;
      end
   end

   assign idle = !running_ff;

endmodule

>>> hw/rtl/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns display requests into timed RS/E/D7..D4 phases for a character LCD
// in 4-bit mode.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake       Transaction
//  req      in         valid/ready     one request (command, char, cursor,
//                                      integer or power-up)
//  rsp      out        valid/ready     one pin phase with hold time
//  csr      in         write enable    one register write, no wait
//
// Each phase leaves at one per cycle through the output register unless rsp
// stalls; a byte is five phases, power-up is 36. An integer of d digits
// first passes the divide-by-ten step, then 5*d phases. A new request is taken
// once the last phase of the previous one sits in the output register.
// Reset is synchronous and restores the register defaults. A stalled rsp
// holds the sequencer at its current phase.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
   input  logic             clock,
   input  logic             reset,
   clcd_req_if.sink         req,
   clcd_rsp_if.source       rsp,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [9:0]       csr_wdata
);

   logic [clcd_pkg::TIME_W-1:0] pulse_ff;
   logic [clcd_pkg::TIME_W-1:0] settle_ff;
   logic [clcd_pkg::TIME_W-1:0] power_wait_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   clcd_pkg::phase_type         rsp_phase_ff;
   logic                        start;
   logic                        idle;
   logic                        emit;
   logic                        out_free;
   clcd_pkg::phase_type         phase;
   clcd_pkg::dig_ctl_type       dig_ctl;
   clcd_pkg::dig_stat_type      dig_stat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff      <= clcd_pkg::PULSE_RESET;
         settle_ff     <= clcd_pkg::SETTLE_RESET;
         power_wait_ff <= clcd_pkg::POWER_WAIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            clcd_pkg::CSR_PULSE:      pulse_ff      <= csr_wdata;
            clcd_pkg::CSR_SETTLE:     settle_ff     <= csr_wdata;
            clcd_pkg::CSR_POWER_WAIT: power_wait_ff <= csr_wdata;
            default:                  ;
         endcase
      end
   end

   assign req.ready = idle;
   assign start     = req.valid && idle;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   clcd_digits u_digits (
      .clock  (clock),
      .reset  (reset),
      .ctl    (dig_ctl),
      .number (req.number),
      .stat   (dig_stat)
   );

   clcd_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .kind          (req.kind),
      .byte_value    (req.byte_value),
      .row           (req.row),
      .column        (req.column),
      .pulse_us      (pulse_ff),
      .settle_us     (settle_ff),
      .power_wait_us (power_wait_ff),
      .out_free      (out_free),
      .dig_stat      (dig_stat),
      .idle          (idle),
      .emit          (emit),
      .phase         (phase),
      .dig_ctl       (dig_ctl)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_phase_ff <= phase;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.reg_select = rsp_phase_ff.reg_select;
   assign rsp.enable     = rsp_phase_ff.enable;
   assign rsp.nibble     = rsp_phase_ff.nibble;
   assign rsp.hold_us    = rsp_phase_ff.hold_us;
   assign rsp.last       = rsp_phase_ff.last;

endmodule
